// ===== src/sbl_pkg.sv =====
// Shared types and constants for the spectrum bar LED renderer.
package sbl_pkg;

    // Request actions
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] CFG_BRIGHTNESS = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_TIMEOUT    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_MIN_X      = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_MAX_X      = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_MIN_Y      = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_MAX_Y      = 3'd5;

    // Configuration reset values
    localparam logic [7:0]  RST_BRIGHTNESS = 8'd255;
    localparam logic [15:0] RST_TIMEOUT    = 16'd500;
    localparam logic [7:0]  RST_MIN_X      = 8'd0;
    localparam logic [7:0]  RST_MAX_X      = 8'd224;
    localparam logic [7:0]  RST_MIN_Y      = 8'd0;
    localparam logic [7:0]  RST_MAX_Y      = 8'd64;

    // Shared divider widths: largest dividend is 5100 * 255, largest divisor 11 * 255
    localparam int DIV_NW = 21;
    localparam int DIV_DW = 12;

    // Fixed-point constants
    localparam logic [15:0] LIT_MIN   = 16'd2621;  // 0.04 in Q0.16
    localparam logic [9:0]  DECAY_K   = 10'd287;   // fall rate, /1024
    localparam logic [14:0] ZONE_NUM_K = 15'd100;
    localparam logic [14:0] ZONE_DEN_K = 15'd55;   // green-to-red knee at 0.55
    localparam logic [DIV_NW-1:0] RED_NUM_K = 21'd5100;
    localparam logic [DIV_DW-1:0] RED_DEN_K = 12'd11;
    localparam logic [DIV_NW-1:0] GRN_NUM_K = 21'd1700;
    localparam logic [DIV_DW-1:0] GRN_DEN_K = 12'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  band_index;
        logic [7:0]  band_level;
        logic [7:0]  band_count;
        logic [31:0] now_ms;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
    } t_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out;

endpackage

// ===== src/spectrum_bar_led_renderer_unit.sv =====
// Spectrum bar LED renderer top level: control sequencer, level memories, query math.
// Frame tick: one band per cycle through the read-modify-write loop on the display level
//   memory. LED query: one or two passes through the bit-serial divider; the result then
//   waits in the output register.
// Reset (synchronous, active low) clears configuration to defaults, all levels to zero
//   through the memory valid bits, band count and last write time; no clearing pass.
module spectrum_bar_led_renderer_unit #(
    parameter int MAX_BANDS = 28
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  sbl_pkg::t_in               i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output sbl_pkg::t_out              o_out_data,
    input  logic                       i_cfg_we,
    input  logic [sbl_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [sbl_pkg::CFG_DW-1:0] i_cfg_data
);
    import sbl_pkg::*;

    localparam int AW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int BW = $clog2(MAX_BANDS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TICK   = 3'd1;
    localparam logic [2:0] S_QBAND  = 3'd2;
    localparam logic [2:0] S_QBWAIT = 3'd3;
    localparam logic [2:0] S_QLVL   = 3'd4;
    localparam logic [2:0] S_QSET   = 3'd5;
    localparam logic [2:0] S_QCWAIT = 3'd6;
    localparam logic [2:0] S_QOUT   = 3'd7;

    logic [2:0]  r_state, n_state;

    logic [7:0]  r_bright;
    logic [15:0] r_timeout;
    logic [7:0]  r_min_x, r_max_x, r_min_y, r_max_y;

    logic [BW-1:0] r_bands;
    logic [31:0]   r_last_time;
    logic          r_stale;
    logic [AW-1:0] r_rd_idx;
    logic          r_rd_done;
    logic          r_wb_vld;
    logic [AW-1:0] r_wb_idx;
    logic [7:0]    r_dx;
    logic [8:0]    r_num;       // max_y - pos_y, two's complement
    logic          r_lit;
    logic          r_zone_red;
    logic [7:0]    r_red, r_green;
    logic          r_out_vld;
    t_out          r_out;

    logic          accept;
    logic          out_free;
    logic [7:0]    raw_rdata;
    logic [15:0]   disp_rdata;
    logic          raw_we;
    logic [AW-1:0] disp_raddr;

    logic [BW-1:0] q_n;
    logic [7:0]    spanx, spany;
    logic [AW-1:0] band_sel;
    logic [8+BW-1:0] band_prod;

    logic          div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_quo;
    logic [DIV_DW-1:0] div_den;

    logic [15:0]   tgt, dec_next, diff;
    logic [25:0]   dec_prod;
    logic          in_use;

    logic [23:0]   lhs, rhs;
    logic          n_lit, n_zone_red;
    logic          need_div;
    logic [7:0]    quo_sat;
    logic [16:0]   sc_r, sc_g;

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_vld || !i_out_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright  <= RST_BRIGHTNESS;
            r_timeout <= RST_TIMEOUT;
            r_min_x   <= RST_MIN_X;
            r_max_x   <= RST_MAX_X;
            r_min_y   <= RST_MIN_Y;
            r_max_y   <= RST_MAX_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BRIGHTNESS: r_bright  <= i_cfg_data[7:0];
                CFG_TIMEOUT:    r_timeout <= i_cfg_data;
                CFG_MIN_X:      r_min_x   <= i_cfg_data[7:0];
                CFG_MAX_X:      r_max_x   <= i_cfg_data[7:0];
                CFG_MIN_Y:      r_min_y   <= i_cfg_data[7:0];
                CFG_MAX_Y:      r_max_y   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Raw levels, written by band writes, read during the tick walk
    assign raw_we = accept && (i_in_data.action == ACT_WRITE) &&
                    (32'(i_in_data.band_index) < 32'(MAX_BANDS));

    sbl_level_ram #(.DEPTH(MAX_BANDS), .WIDTH(8), .AW(AW)) u_raw_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (raw_we),
        .i_waddr (AW'(i_in_data.band_index)),
        .i_wdata (i_in_data.band_level),
        .i_raddr (r_rd_idx),
        .o_rdata (raw_rdata)
    );

    // Display levels: tick reads band i while writing back band i-1, so no overlap
    assign disp_raddr = (r_state == S_TICK) ? r_rd_idx : band_sel;

    sbl_level_ram #(.DEPTH(MAX_BANDS), .WIDTH(16), .AW(AW)) u_disp_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_wb_vld),
        .i_waddr (r_wb_idx),
        .i_wdata (dec_next),
        .i_raddr (disp_raddr),
        .o_rdata (disp_rdata)
    );

    // Rise at once, fall by 287/1024 of the gap
    always_comb begin
        in_use   = BW'(r_wb_idx) < r_bands;
        tgt      = (r_stale || !in_use) ? 16'd0 : {raw_rdata, raw_rdata};
        diff     = disp_rdata - tgt;
        dec_prod = 26'(diff) * 26'(DECAY_K);
        dec_next = (tgt > disp_rdata) ? tgt : (disp_rdata - dec_prod[25:10]);
    end

    // Geometry from configuration
    always_comb begin
        q_n       = (r_bands == '0) ? BW'(1) : r_bands;
        spanx     = (r_max_x > r_min_x) ? (r_max_x - r_min_x) : 8'd1;
        spany     = (r_max_y > r_min_y) ? (r_max_y - r_min_y) : 8'd1;
        band_prod = (8+BW)'(r_dx) * (8+BW)'(q_n);
        band_sel  = (div_quo >= DIV_NW'(q_n)) ? AW'(q_n - 1'b1) : AW'(div_quo);
    end

    // Lit test and color zone
    always_comb begin
        lhs        = 24'(disp_rdata) * 24'(spany);
        rhs        = {r_num[7:0], 16'd0} - 24'(r_num[7:0]);
        n_lit      = (disp_rdata > LIT_MIN) && (r_num[8] || (lhs > rhs));
        n_zone_red = r_num[8] ||
                     ((15'(r_num[7:0]) * ZONE_NUM_K) < (15'(spany) * ZONE_DEN_K));
        need_div   = r_lit && (r_zone_red ? !r_num[8] : (r_num[7:0] < spany));
    end

    // Shared divider operand select
    always_comb begin
        div_start = (r_state == S_QBAND) || ((r_state == S_QSET) && need_div);
        if (r_state == S_QBAND) begin
            div_num = DIV_NW'(band_prod);
            div_den = DIV_DW'(spanx);
        end else if (r_zone_red) begin
            div_num = DIV_NW'(r_num[7:0]) * RED_NUM_K;
            div_den = DIV_DW'(spany) * RED_DEN_K;
        end else begin
            div_num = DIV_NW'(spany - r_num[7:0]) * GRN_NUM_K;
            div_den = DIV_DW'(spany) * GRN_DEN_K;
        end
    end

    sbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Channel saturation and brightness scaling
    always_comb begin
        quo_sat = (div_quo > DIV_NW'(255)) ? 8'd255 : div_quo[7:0];
        sc_r    = 17'(r_red)   * 17'({1'b0, r_bright} + 9'd1);
        sc_g    = 17'(r_green) * 17'({1'b0, r_bright} + 9'd1);
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.action)
                        ACT_TICK:  n_state = S_TICK;
                        ACT_QUERY: n_state = S_QBAND;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_TICK:   if (r_rd_done && r_wb_vld) n_state = S_IDLE;
            S_QBAND:  n_state = S_QBWAIT;
            S_QBWAIT: if (div_done) n_state = S_QLVL;
            S_QLVL:   n_state = S_QSET;
            S_QSET:   n_state = need_div ? S_QCWAIT : S_QOUT;
            S_QCWAIT: if (div_done) n_state = S_QOUT;
            S_QOUT:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bands     <= '0;
            r_last_time <= '0;
            r_wb_vld    <= 1'b0;
            r_rd_done   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && (i_in_data.action == ACT_WRITE)) begin
                r_bands     <= (32'(i_in_data.band_count) > 32'(MAX_BANDS)) ?
                               BW'(MAX_BANDS) : BW'(i_in_data.band_count);
                r_last_time <= i_in_data.now_ms;
            end
            if (accept) begin
                r_rd_done <= 1'b0;
                r_wb_vld  <= 1'b0;
            end else if (r_state == S_TICK) begin
                r_wb_vld <= !r_rd_done;
                if (r_rd_idx == AW'(MAX_BANDS - 1)) begin
                    r_rd_done <= 1'b1;
                end
            end else begin
                r_wb_vld <= 1'b0;
            end
            if ((r_state == S_QOUT) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stale  <= (i_in_data.now_ms - r_last_time) > {16'd0, r_timeout};
            r_rd_idx <= '0;
            r_dx     <= (i_in_data.pos_x > r_min_x) ? (i_in_data.pos_x - r_min_x) : 8'd0;
            r_num    <= {1'b0, r_max_y} - {1'b0, i_in_data.pos_y};
        end else if ((r_state == S_TICK) && !r_rd_done &&
                     (r_rd_idx != AW'(MAX_BANDS - 1))) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        if (r_state == S_TICK) begin
            r_wb_idx <= r_rd_idx;
        end
        if (r_state == S_QLVL) begin
            r_lit      <= n_lit;
            r_zone_red <= n_zone_red;
        end
        if (r_state == S_QSET) begin
            if (!r_lit) begin
                r_red   <= 8'd0;
                r_green <= 8'd0;
            end else if (r_zone_red) begin
                r_red   <= 8'd0;
                r_green <= 8'd255;
            end else begin
                r_red   <= 8'd255;
                r_green <= 8'd0;
            end
        end
        if ((r_state == S_QCWAIT) && div_done) begin
            if (r_zone_red) begin
                r_red <= quo_sat;
            end else begin
                r_green <= quo_sat;
            end
        end
        if ((r_state == S_QOUT) && out_free) begin
            r_out.red   <= sc_r[15:8];
            r_out.green <= sc_g[15:8];
            r_out.blue  <= 8'd0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== src/sbl_level_ram.sv =====
// Band level memory: one write port, one registered read port, per-entry valid bits.
module sbl_level_ram #(
    parameter int DEPTH = 28,
    parameter int WIDTH = 8,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sbl_div.sv =====
// Restoring divider, one quotient bit per cycle.
module sbl_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sbl_pkg::DIV_NW-1:0] i_num,
    input  logic [sbl_pkg::DIV_DW-1:0] i_den,
    output logic                      o_done,
    output logic [sbl_pkg::DIV_NW-1:0] o_quo
);
    import sbl_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_den;

    logic [DIV_DW:0]   trial;
    logic              ge;
    logic [DIV_DW-1:0] n_rem;

    // One trial subtraction
    always_comb begin
        trial = {r_rem, r_quo[DIV_NW-1]};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? DIV_DW'(trial - {1'b0, r_den}) : DIV_DW'(trial);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== tb/sbl_colour_checker.sv =====
// Checker for the spectrum bar LED renderer: level predictor, color scoreboard and compare.
`timescale 1ns / 1ps

module sbl_colour_checker #(
    parameter int BAND_SLOTS = 28
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  sbl_pkg::t_in               i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  sbl_pkg::t_out              i_out_data,
    input  logic                       i_cfg_we,
    input  logic [sbl_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [sbl_pkg::CFG_DW-1:0] i_cfg_data,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_nonblack
);
    import sbl_pkg::*;

    // Predicted block state
    logic [7:0]  raw_band [BAND_SLOTS];
    logic [15:0] shown_level [BAND_SLOTS];
    int          band_total;
    logic [31:0] last_stamp;

    // Predicted configuration
    logic [7:0]  bright;
    logic [15:0] stale_ms;
    logic [7:0]  x_lo, x_hi, y_lo, y_hi;

    // Colors still owed by the block, oldest first
    t_out colour_q[$];
    int   mismatches = 0;
    int   checked    = 0;
    int   nonblack   = 0;

    // Expected color of the LED at (px, py) from the current bar levels
    function automatic t_out colour_of(logic [7:0] px, logic [7:0] py);
        longint n, span_x, span_y, dx, band, num, level, r, g;
        t_out   c;
        n      = (band_total != 0) ? longint'(band_total) : 1;
        span_x = (x_hi > x_lo) ? longint'(x_hi) - longint'(x_lo) : 1;
        span_y = (y_hi > y_lo) ? longint'(y_hi) - longint'(y_lo) : 1;
        dx     = (px > x_lo) ? longint'(px) - longint'(x_lo) : 0;
        band   = dx * n / span_x;
        if (band >= n) band = n - 1;
        if (band >= BAND_SLOTS) band = BAND_SLOTS - 1;
        level = longint'(shown_level[band]);
        num   = longint'(y_hi) - longint'(py);
        r = 0;
        g = 0;
        // lit when above the floor and the bar top is strictly above this row
        if (level > longint'(LIT_MIN) && level * span_y > num * 65535) begin
            if (num * 100 < 55 * span_y) begin
                // green zone: red ramps up to the knee at 0.55
                r = (num < 0) ? 0 : (5100 * num) / (11 * span_y);
                if (r > 255) r = 255;
                g = 255;
            end else begin
                // red zone: green ramps down over the top 0.45
                r = 255;
                g = (num >= span_y) ? 0 : (1700 * (span_y - num)) / (3 * span_y);
                if (g > 255) g = 255;
            end
        end
        c.red   = 8'((r * (longint'(bright) + 1)) >> 8);
        c.green = 8'((g * (longint'(bright) + 1)) >> 8);
        c.blue  = 8'd0;
        return c;
    endfunction

    task automatic note_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out        want;
        logic [31:0] age;
        logic        stale;
        int          target, cur;
        if (!i_rst_n) begin
            for (int b = 0; b < BAND_SLOTS; b++) begin
                raw_band[b]    = '0;
                shown_level[b] = '0;
            end
            band_total = 0;
            last_stamp = '0;
            bright     = RST_BRIGHTNESS;
            stale_ms   = RST_TIMEOUT;
            x_lo       = RST_MIN_X;
            x_hi       = RST_MAX_X;
            y_lo       = RST_MIN_Y;
            y_hi       = RST_MAX_Y;
            colour_q.delete();
        end else begin
            // result side first: anything leaving now was requested earlier
            if (i_out_valid && !i_out_stall) begin
                if (colour_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: color %0d/%0d/%0d arrived with none expected",
                             $time, i_out_data.red, i_out_data.green, i_out_data.blue);
                end else begin
                    want = colour_q.pop_front();
                    checked++;
                    note_field("red", want.red, i_out_data.red);
                    note_field("green", want.green, i_out_data.green);
                    note_field("blue", want.blue, i_out_data.blue);
                end
            end

            // register writes; unused indexes fall through
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BRIGHTNESS: bright   = i_cfg_data[7:0];
                    CFG_TIMEOUT:    stale_ms = i_cfg_data;
                    CFG_MIN_X:      x_lo     = i_cfg_data[7:0];
                    CFG_MAX_X:      x_hi     = i_cfg_data[7:0];
                    CFG_MIN_Y:      y_lo     = i_cfg_data[7:0];
                    CFG_MAX_Y:      y_hi     = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // accepted request
            if (i_in_valid && !i_in_stall) begin
                case (i_in_data.action)
                    ACT_WRITE: begin
                        // out-of-range band drops the level but still moves count and time
                        if (i_in_data.band_index < BAND_SLOTS)
                            raw_band[i_in_data.band_index] = i_in_data.band_level;
                        band_total = (i_in_data.band_count > BAND_SLOTS) ? BAND_SLOTS
                                                                         : int'(i_in_data.band_count);
                        last_stamp = i_in_data.now_ms;
                    end
                    ACT_TICK: begin
                        age   = i_in_data.now_ms - last_stamp;
                        stale = age > 32'(stale_ms);
                        for (int b = 0; b < BAND_SLOTS; b++) begin
                            target = (stale || b >= band_total) ? 0 : int'(raw_band[b]) * 257;
                            cur    = int'(shown_level[b]);
                            // jump up at once, fall by a fraction of the gap
                            if (target > cur)
                                cur = target;
                            else
                                cur = cur - (((cur - target) * int'(DECAY_K)) >>> 10);
                            shown_level[b] = 16'(cur);
                        end
                    end
                    ACT_QUERY: begin
                        want = colour_of(i_in_data.pos_x, i_in_data.pos_y);
                        if (want.red != 0 || want.green != 0) nonblack++;
                        colour_q.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
        o_pending    <= colour_q.size();
        o_mismatches <= mismatches;
        o_checked    <= checked;
        o_nonblack   <= nonblack;
    end

endmodule

// ===== tb/spectrum_bar_led_renderer_unit_tb.sv =====
// Testbench top for the spectrum bar LED renderer: clock, reset, requests, settings, verdict.
`timescale 1ns / 1ps

module spectrum_bar_led_renderer_unit_tb;
    import sbl_pkg::*;

    localparam int IDLE_LIMIT    = 3000;  // cycles with no request or result moving
    localparam int SETTLE_CYCLES = 64;    // longest busy time after the last color
    localparam int DIRECTED_LEN  = 25;
    localparam int PHASE_LEN     = 230;
    localparam int PHASES        = 8;
    localparam logic [CFG_IW-1:0] CFG_SPARE = 3'd7;  // no register behind it

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in               i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out              o_out_data;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data  = '0;

    int mismatches, pending, checked, nonblack;

    // Run statistics and generator state
    int          n_write = 0, n_tick = 0, n_query = 0, n_ignored = 0, n_settings = 0;
    int          n_counted = 0;
    bit          calm = 1'b0;
    logic [7:0]  lo_x = RST_MIN_X, hi_x = RST_MAX_X, lo_y = RST_MIN_Y, hi_y = RST_MAX_Y;
    logic [15:0] tmo_ms = RST_TIMEOUT;
    logic [7:0]  frame_bands = 8'd8;
    logic [31:0] stamp = '0;
    int          stall_left = 0, stall_len = 0, quiet_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    spectrum_bar_led_renderer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sbl_colour_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_nonblack   (nonblack)
    );

    // Idle length: mostly none, sometimes short, rarely long
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in mk(logic [1:0] act, logic [4:0] idx, logic [7:0] lvl,
                               logic [7:0] cnt, logic [31:0] now, logic [7:0] px,
                               logic [7:0] py);
        t_in r;
        r.action     = act;
        r.band_index = idx;
        r.band_level = lvl;
        r.band_count = cnt;
        r.now_ms     = now;
        r.pos_x      = px;
        r.pos_y      = py;
        return r;
    endfunction

    // Result-side back-pressure, independent of valid
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            stall_len = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            i_out_stall <= (stall_len > 0);
            stall_left  <= (stall_len > 0) ? stall_len - 1 : 0;
        end
    end

    // Watchdog on traffic
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles", IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One request, held until taken
    task automatic send(input t_in req);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        case (req.action)
            ACT_WRITE: n_write++;
            ACT_TICK:  n_tick++;
            ACT_QUERY: n_query++;
            default:   n_ignored++;
        endcase
        if (req.action == ACT_WRITE || req.action == ACT_TICK || req.action == ACT_QUERY)
            n_counted++;
    endtask

    // Stop sending, let every color come out, then let a tick finish
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Full register set; unused upper bits of the 8-bit registers carry noise
    task automatic configure(input logic [7:0] bright, input logic [15:0] tmo,
                             input logic [7:0] x0, input logic [7:0] x1,
                             input logic [7:0] y0, input logic [7:0] y1);
        write_reg(CFG_BRIGHTNESS, {8'($urandom), bright});
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_MIN_X, {8'($urandom), x0});
        write_reg(CFG_MAX_X, {8'($urandom), x1});
        write_reg(CFG_MIN_Y, {8'($urandom), y0});
        write_reg(CFG_MAX_Y, {8'($urandom), y1});
        write_reg(CFG_SPARE, 16'($urandom));
        i_cfg_we <= 1'b0;
        lo_x   = x0;
        hi_x   = x1;
        lo_y   = y0;
        hi_y   = y1;
        tmo_ms = tmo;
        n_settings++;
    endtask

    // Mostly whole frames (writes, ticks, queries), some raw noise requests
    task automatic random_phase(input int goal);
        int roll, used, k, i;
        logic [7:0] px, py;
        while (n_counted < goal) begin
            if ($urandom_range(0, 49) == 0) calm <= ~calm;
            roll = $urandom_range(0, 99);
            if (roll == 0) begin
                drain();
            end else if (roll < 75) begin
                if ($urandom_range(0, 19) == 0) stamp = $urandom;
                if ($urandom_range(0, 7) == 0) begin
                    roll = $urandom_range(0, 19);
                    if (roll < 14)      frame_bands = 8'($urandom_range(1, 28));
                    else if (roll < 17) frame_bands = 8'($urandom_range(29, 255));
                    else                frame_bands = 8'd0;
                end
                used = (frame_bands > 28) ? 28 : int'(frame_bands);
                // band writes
                k = $urandom_range(0, 5);
                for (i = 0; i < k; i++) begin
                    stamp += $urandom_range(0, 30);
                    send(mk(ACT_WRITE,
                            (used == 0 || $urandom_range(0, 9) == 0) ? 5'($urandom)
                                                                     : 5'($urandom_range(0, used - 1)),
                            ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(96, 255)),
                            frame_bands, stamp, 8'($urandom), 8'($urandom)));
                end
                // frame ticks, now and then past the timeout
                k = $urandom_range(1, 2);
                for (i = 0; i < k; i++) begin
                    stamp += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2 * int'(tmo_ms) + 100)
                                                         : $urandom_range(0, 40);
                    send(mk(ACT_TICK, 5'($urandom), 8'($urandom), 8'($urandom), stamp,
                            8'($urandom), 8'($urandom)));
                end
                // LED queries, mostly on the board
                k = $urandom_range(0, 6);
                for (i = 0; i < k; i++) begin
                    px = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(lo_x, hi_x));
                    py = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(lo_y, hi_y));
                    send(mk(ACT_QUERY, 5'($urandom), 8'($urandom), 8'($urandom), $urandom, px, py));
                end
            end else begin
                send(mk(2'($urandom), 5'($urandom), 8'($urandom), 8'($urandom), $urandom,
                        8'($urandom), 8'($urandom)));
            end
        end
    endtask

    initial begin
        int lo, p;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, board 224 x 64
        send(mk(ACT_QUERY, 5'd0, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0));           // all dark
        send(mk(ACT_WRITE, 5'd0, 8'd255, 8'd4, 32'd100, 8'd0, 8'd0));
        send(mk(ACT_WRITE, 5'd3, 8'd128, 8'd4, 32'd100, 8'd0, 8'd0));
        send(mk(ACT_WRITE, 5'd31, 8'd200, 8'd200, 32'd110, 8'd0, 8'd0));    // bad band, count clamps
        send(mk(ACT_WRITE, 5'd27, 8'd255, 8'd28, 32'd120, 8'd0, 8'd0));
        send(mk(ACT_TICK, 5'd0, 8'd0, 8'd0, 32'd130, 8'd0, 8'd0));          // bars jump up
        send(mk(ACT_QUERY, 5'd0, 8'd0, 8'd0, 32'd0, 8'd0, 8'd64));          // bottom row
        send(mk(ACT_QUERY, 5'd0, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0));           // full bar, top row
        send(mk(ACT_QUERY, 5'd0, 8'd0, 8'd0, 32'd0, 8'd0, 8'd30));          // green zone
        send(mk(ACT_QUERY, 5'd0, 8'd0, 8'd0, 32'd0, 8'd0, 8'd20));          // red zone
        send(mk(ACT_QUERY, 5'd0, 8'd0, 8'd0, 32'd0, 8'd84, 8'd40));         // band never written, dark
        send(mk(ACT_QUERY, 5'd0, 8'd0, 8'd0, 32'd0, 8'd224, 8'd64));        // last band
        send(mk(ACT_QUERY, 5'd0, 8'd0, 8'd0, 32'd0, 8'd255, 8'd255));       // off the board
        send(mk(2'd3, 5'd31, 8'd255, 8'd255, 32'hFFFF_FFFF, 8'd255, 8'd255)); // ignored
        send(mk(ACT_TICK, 5'd0, 8'd0, 8'd0, 32'd5000, 8'd0, 8'd0));         // stale, bars fall
        send(mk(ACT_TICK, 5'd0, 8'd0, 8'd0, 32'd5001, 8'd0, 8'd0));
        send(mk(ACT_QUERY, 5'd0, 8'd0, 8'd0, 32'd0, 8'd0, 8'd40));
        send(mk(ACT_WRITE, 5'd5, 8'd10, 8'd0, 32'd6000, 8'd0, 8'd0));       // no bands in use
        send(mk(ACT_TICK, 5'd0, 8'd0, 8'd0, 32'd6000, 8'd0, 8'd0));
        send(mk(ACT_QUERY, 5'd0, 8'd0, 8'd0, 32'd0, 8'd100, 8'd10));
        send(mk(ACT_WRITE, 5'd1, 8'd255, 8'd2, 32'hFFFF_FFF0, 8'd0, 8'd0));
        send(mk(ACT_TICK, 5'd0, 8'd0, 8'd0, 32'h0000_0010, 8'd0, 8'd0));    // time wraps, fresh
        send(mk(ACT_QUERY, 5'd0, 8'd0, 8'd0, 32'd0, 8'd200, 8'd60));
        send(mk(ACT_WRITE, 5'd27, 8'd255, 8'd255, 32'hFFFF_FFFF, 8'd255, 8'd255));
        send(mk(ACT_TICK, 5'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 8'd0, 8'd0));

        // Random phases, each under its own register setting
        for (p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: configure(8'd200, 16'd300, 8'd0, 8'd224, 8'd0, 8'd64);
                1: configure(8'd0, 16'd0, 8'd0, 8'd255, 8'd0, 8'd255);
                2: configure(8'd255, 16'd65535, 8'd255, 8'd0, 8'd255, 8'd0);
                3: configure(8'd128, 16'd1000, 8'd100, 8'd100, 8'd30, 8'd30);
                7: configure(8'd255, 16'd500, 8'd0, 8'd224, 8'd0, 8'd64);
                default: begin
                    lo = $urandom_range(0, 120);
                    configure(8'($urandom), 16'($urandom_range(0, 3000)), 8'(lo),
                              8'($urandom_range(lo + 1, 255)), 8'(lo / 2),
                              8'($urandom_range(lo / 2 + 1, 255)));
                end
            endcase
            random_phase(DIRECTED_LEN + (p + 1) * PHASE_LEN);
        end
        drain();

        $display("Sent %0d band writes, %0d frame ticks, %0d LED queries, %0d ignored requests",
                 n_write, n_tick, n_query, n_ignored);
        $display("over %0d register settings; %0d colors compared, %0d of them lit.",
                 n_settings + 1, checked, nonblack);
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
